/* hdl/rotated_cubic_stiffness_component_assert.svh */
// Assertion macros for the rotated cubic stiffness component.
// Both macros expect aclk and aresetn in the scope where they are used.
`ifndef ROTATED_CUBIC_STIFFNESS_COMPONENT_ASSERT_SVH
`define ROTATED_CUBIC_STIFFNESS_COMPONENT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define RCSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define RCSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RCSC_ASSERT_NOW(lbl, ante, cons, msg)
`define RCSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/rcsc_pkg.sv */
package rcsc_pkg;

    // Field widths.
    localparam int GRAIN_W      = 6;
    localparam int IDX_W        = 2;
    localparam int ENTRY_W      = 16;
    localparam int COEF_W       = 32;
    localparam int COMP_W       = 40;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = COMP_W;
    localparam int CFG_INDEX_W  = 2;

    // Arithmetic widths.
    localparam int PAIR_W       = 2 * ENTRY_W;
    localparam int SUM_W        = 64;
    localparam int ACC_W        = 96;
    localparam int FRAC_BITS    = 56;
    localparam int FULL_ADDR_W  = 10;
    localparam int ENTRIES_PER_GRAIN = 9;
    localparam int NUM_TERMS    = 15;
    localparam int TERM_W       = 4;

    // Command codes carried in s_tuser.
    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_EVALUATE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_C_ELEVEN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_C_TWELVE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_C_FORTY_FOUR = 2'd2;

    // Where a multiplier result goes in the cycle after it is produced.
    localparam logic [2:0] DEST_NONE   = 3'd0;
    localparam logic [2:0] DEST_S11    = 3'd1;
    localparam logic [2:0] DEST_S12    = 3'd2;
    localparam logic [2:0] DEST_S44    = 3'd3;
    localparam logic [2:0] DEST_ACC_LO = 3'd4;
    localparam logic [2:0] DEST_ACC_HI = 3'd5;

    // One nonzero term: columns taken from rows i, j, k, l and the sum it feeds.
    typedef struct packed {
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] q;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] s;
        logic [2:0]       dest;
    } term_t;

    function automatic term_t term_f(input logic [TERM_W-1:0] t);
        term_t e;
        case (t)
            4'd0:    e = '{2'd0, 2'd0, 2'd0, 2'd0, DEST_S11};
            4'd1:    e = '{2'd1, 2'd1, 2'd1, 2'd1, DEST_S11};
            4'd2:    e = '{2'd2, 2'd2, 2'd2, 2'd2, DEST_S11};
            4'd3:    e = '{2'd0, 2'd0, 2'd1, 2'd1, DEST_S12};
            4'd4:    e = '{2'd0, 2'd0, 2'd2, 2'd2, DEST_S12};
            4'd5:    e = '{2'd1, 2'd1, 2'd0, 2'd0, DEST_S12};
            4'd6:    e = '{2'd1, 2'd1, 2'd2, 2'd2, DEST_S12};
            4'd7:    e = '{2'd2, 2'd2, 2'd0, 2'd0, DEST_S12};
            4'd8:    e = '{2'd2, 2'd2, 2'd1, 2'd1, DEST_S12};
            4'd9:    e = '{2'd0, 2'd1, 2'd0, 2'd1, DEST_S44};
            4'd10:   e = '{2'd0, 2'd2, 2'd0, 2'd2, DEST_S44};
            4'd11:   e = '{2'd1, 2'd0, 2'd1, 2'd0, DEST_S44};
            4'd12:   e = '{2'd1, 2'd2, 2'd1, 2'd2, DEST_S44};
            4'd13:   e = '{2'd2, 2'd0, 2'd2, 2'd0, DEST_S44};
            4'd14:   e = '{2'd2, 2'd1, 2'd2, 2'd1, DEST_S44};
            default: e = '{2'd0, 2'd0, 2'd0, 2'd0, DEST_NONE};
        endcase
        return e;
    endfunction

endpackage

/* hdl/rotated_cubic_stiffness_component.sv */
// An evaluate is accepted only while idle; it loads 12 table entries, then runs 15 terms of
// 3 multiplier passes, 6 scaling passes, a drain and an emit state, which waits while an
// earlier result is still held. s_tready returns as the result shows on m_tvalid, so a new
// transaction waits until the last evaluate is through. A write or dropped evaluate stays idle.
// Reset (aresetn low, synchronous) clears the sequencer, output valid and the stiffness
// constants; the rotation table is not cleared and reads undefined until written.
`include "rotated_cubic_stiffness_component_assert.svh"

module rotated_cubic_stiffness_component #(
    parameter int MAX_GRAINS = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input transactions.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // From bit 0: grain[5:0], row[7:6], col[9:8], entry_value[25:10], index_i[27:26],
    // index_j[29:28], index_k[31:30], index_l[33:32], zero fill[39:34].
    input  logic [rcsc_pkg::S_TDATA_W-1:0]       s_tdata,
    // command: 0 writes a rotation entry, 1 evaluates a component.
    input  logic                                 s_tuser,
    // Result transactions.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // From bit 0: component[39:0].
    output logic [rcsc_pkg::M_TDATA_W-1:0]       m_tdata,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rcsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rcsc_pkg::COEF_W-1:0]          cfg_data
);
    import rcsc_pkg::*;

    // Only grains that the 6-bit field can name need storage.
    localparam int MEM_GRAINS = (MAX_GRAINS < (1 << GRAIN_W)) ? MAX_GRAINS : (1 << GRAIN_W);
    localparam int MEM_DEPTH  = MEM_GRAINS * ENTRIES_PER_GRAIN;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    // Input field unpacking.
    logic [GRAIN_W-1:0] in_grain;
    logic [IDX_W-1:0]   in_row;
    logic [IDX_W-1:0]   in_col;
    logic [ENTRY_W-1:0] in_entry;
    logic [IDX_W-1:0]   in_idx [4];

    assign in_grain  = s_tdata[5:0];
    assign in_row    = s_tdata[7:6];
    assign in_col    = s_tdata[9:8];
    assign in_entry  = s_tdata[25:10];
    assign in_idx[0] = s_tdata[27:26];
    assign in_idx[1] = s_tdata[29:28];
    assign in_idx[2] = s_tdata[31:30];
    assign in_idx[3] = s_tdata[33:32];

    // Registers.
    logic [2:0]              state_reg, state_next;
    logic                    ld_issue_reg;
    logic [1:0]              ld_row_reg;
    logic [IDX_W-1:0]        ld_col_reg;
    logic                    cap_valid_reg;
    logic [1:0]              cap_row_reg;
    logic [IDX_W-1:0]        cap_col_reg;
    logic [TERM_W-1:0]       term_cnt_reg;
    logic [1:0]              phase_reg;
    logic [2:0]              sc_cnt_reg;
    logic [2:0]              pend_dest_reg, pend_dest_next;
    logic                    m_tvalid_reg;
    logic [COMP_W-1:0]       m_tdata_reg;
    logic signed [COEF_W-1:0] c_eleven_reg, c_twelve_reg, c_forty_four_reg;

    logic [GRAIN_W-1:0]      grain_reg;
    logic [IDX_W-1:0]        idx_reg [4];
    logic signed [ENTRY_W-1:0] bank_reg [4][3];
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic signed [PAIR_W-1:0] pair_reg;
    logic signed [SUM_W-1:0] mult_out_reg;
    logic signed [SUM_W-1:0] s11_reg, s12_reg, s44_reg;
    logic [ACC_W-1:0]        acc_reg;

    logic [ENTRY_W-1:0]      mem [MEM_DEPTH];

    // Handshake decode.
    logic s_accept;
    logic grain_ok;
    logic write_ok;
    logic eval_ok;
    logic eval_start;
    logic out_free;
    logic load_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // A grain beyond the table, or an index of three, makes the transaction a no-op.
    assign grain_ok = (32'(in_grain) < MAX_GRAINS);
    assign write_ok = grain_ok && (in_row != 2'd3) && (in_col != 2'd3);
    assign eval_ok  = grain_ok && (in_idx[0] != 2'd3) && (in_idx[1] != 2'd3)
                      && (in_idx[2] != 2'd3) && (in_idx[3] != 2'd3);
    assign eval_start = s_accept && (s_tuser == CMD_EVALUATE) && eval_ok;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign load_last  = cap_valid_reg && (cap_row_reg == 2'd3) && (cap_col_reg == 2'd2);

    // Table addressing: grain * 9 + row * 3 + col, built from shifts and adds.
    function automatic logic [FULL_ADDR_W-1:0] addr_f(
        input logic [GRAIN_W-1:0] g,
        input logic [IDX_W-1:0]   r,
        input logic [IDX_W-1:0]   c
    );
        return {1'b0, g, 3'b000} + {4'b0, g} + {7'b0, r, 1'b0} + {8'b0, r} + {8'b0, c};
    endfunction

    logic [FULL_ADDR_W-1:0] wr_full_addr;
    logic [FULL_ADDR_W-1:0] rd_full_addr;
    logic                   mem_we;
    logic                   rd_en;

    assign wr_full_addr = addr_f(in_grain, in_row, in_col);
    assign rd_full_addr = addr_f(grain_reg, idx_reg[ld_row_reg], ld_col_reg);
    assign mem_we = s_accept && (s_tuser == CMD_WRITE) && write_ok;
    assign rd_en  = (state_reg == ST_LOAD) && ld_issue_reg;

    // Rotation table: one write port for write transactions, one registered read port
    // that the load phase uses to fetch rows i, j, k and l of the selected grain.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_full_addr[ADDR_W-1:0]] <= in_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_full_addr[ADDR_W-1:0]];
        end
    end

    // Shared multiplier operand selection. Each term R(i,p)R(j,q)R(k,r)R(l,s) takes
    // three passes: the i-j pair, the k-l pair, then the product of the two pairs.
    // The scaling phase multiplies each 64-bit sum by its constant in two halves.
    term_t                    term_s;
    logic signed [32:0]       op_a;
    logic signed [COEF_W-1:0] op_b;
    logic signed [SUM_W-1:0]  mult_prod;
    logic signed [SUM_W-1:0]  sum_sel;
    logic signed [COEF_W-1:0] coef_sel;

    assign term_s = term_f(term_cnt_reg);

    always_comb begin
        case (sc_cnt_reg[2:1])
            2'd0: begin
                sum_sel  = s11_reg;
                coef_sel = c_eleven_reg;
            end
            2'd1: begin
                sum_sel  = s12_reg;
                coef_sel = c_twelve_reg;
            end
            2'd2: begin
                sum_sel  = s44_reg;
                coef_sel = c_forty_four_reg;
            end
            default: begin
                sum_sel  = '0;
                coef_sel = '0;
            end
        endcase
    end

    always_comb begin
        op_a           = '0;
        op_b           = '0;
        pend_dest_next = DEST_NONE;
        case (state_reg)
            ST_CALC: begin
                case (phase_reg)
                    2'd0: begin
                        op_a = {{17{bank_reg[0][term_s.p][ENTRY_W-1]}}, bank_reg[0][term_s.p]};
                        op_b = {{16{bank_reg[1][term_s.q][ENTRY_W-1]}}, bank_reg[1][term_s.q]};
                    end
                    2'd1: begin
                        op_a = {{17{bank_reg[2][term_s.r][ENTRY_W-1]}}, bank_reg[2][term_s.r]};
                        op_b = {{16{bank_reg[3][term_s.s][ENTRY_W-1]}}, bank_reg[3][term_s.s]};
                    end
                    2'd2: begin
                        op_a           = {pair_reg[PAIR_W-1], pair_reg};
                        op_b           = mult_out_reg[PAIR_W-1:0];
                        pend_dest_next = term_s.dest;
                    end
                    default: begin
                        op_a = '0;
                    end
                endcase
            end
            ST_SCALE: begin
                op_b = coef_sel;
                if (sc_cnt_reg[0] == 1'b0) begin
                    // Low half of the sum is unsigned.
                    op_a           = {1'b0, sum_sel[31:0]};
                    pend_dest_next = DEST_ACC_LO;
                end else begin
                    op_a           = {sum_sel[SUM_W-1], sum_sel[SUM_W-1:32]};
                    pend_dest_next = DEST_ACC_HI;
                end
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    assign mult_prod = op_a * op_b;

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (eval_start) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (load_last) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if ((phase_reg == 2'd2) && (term_cnt_reg == TERM_W'(NUM_TERMS - 1))) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (sc_cnt_reg == 3'd5) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ld_issue_reg     <= 1'b0;
            ld_row_reg       <= '0;
            ld_col_reg       <= '0;
            cap_valid_reg    <= 1'b0;
            cap_row_reg      <= '0;
            cap_col_reg      <= '0;
            term_cnt_reg     <= '0;
            phase_reg        <= '0;
            sc_cnt_reg       <= '0;
            pend_dest_reg    <= DEST_NONE;
            m_tvalid_reg     <= 1'b0;
            c_eleven_reg     <= '0;
            c_twelve_reg     <= '0;
            c_forty_four_reg <= '0;
        end else begin
            state_reg     <= state_next;
            pend_dest_reg <= pend_dest_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_C_ELEVEN:     c_eleven_reg     <= cfg_data;
                    CFG_C_TWELVE:     c_twelve_reg     <= cfg_data;
                    CFG_C_FORTY_FOUR: c_forty_four_reg <= cfg_data;
                    default:          c_eleven_reg     <= c_eleven_reg;
                endcase
            end

            if (eval_start) begin
                ld_issue_reg  <= 1'b1;
                ld_row_reg    <= '0;
                ld_col_reg    <= '0;
                cap_valid_reg <= 1'b0;
                term_cnt_reg  <= '0;
                phase_reg     <= '0;
                sc_cnt_reg    <= '0;
            end

            // Capture into the row bank happens in the cycle after read issue.
            if (state_reg == ST_LOAD) begin
                cap_valid_reg <= ld_issue_reg;
                if (ld_issue_reg) begin
                    cap_row_reg <= ld_row_reg;
                    cap_col_reg <= ld_col_reg;
                    if (ld_col_reg == 2'd2) begin
                        ld_col_reg <= '0;
                        ld_row_reg <= ld_row_reg + 2'd1;
                        if (ld_row_reg == 2'd3) begin
                            ld_issue_reg <= 1'b0;
                        end
                    end else begin
                        ld_col_reg <= ld_col_reg + 2'd1;
                    end
                end
            end

            if (state_reg == ST_CALC) begin
                if (phase_reg == 2'd2) begin
                    phase_reg    <= '0;
                    term_cnt_reg <= term_cnt_reg + TERM_W'(1);
                end else begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end

            if (state_reg == ST_SCALE) begin
                sc_cnt_reg <= sc_cnt_reg + 3'd1;
            end

            if ((state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        mult_out_reg <= mult_prod;

        if (eval_start) begin
            grain_reg <= in_grain;
            for (int n = 0; n < 4; n++) begin
                idx_reg[n] <= in_idx[n];
            end
        end

        if (cap_valid_reg) begin
            bank_reg[cap_row_reg][cap_col_reg] <= rd_data_reg;
        end

        // The i-j pair is parked while the k-l pair is formed.
        if ((state_reg == ST_CALC) && (phase_reg == 2'd1)) begin
            pair_reg <= mult_out_reg[PAIR_W-1:0];
        end

        // Products are folded in the cycle after they leave the multiplier. The term
        // sums wrap at 64 bits; the final accumulator starts at one half LSB so that
        // taking the top bits rounds to nearest, ties toward plus infinity.
        if (eval_start) begin
            s11_reg <= '0;
            s12_reg <= '0;
            s44_reg <= '0;
            acc_reg <= ACC_W'(1) << (FRAC_BITS - 1);
        end else begin
            case (pend_dest_reg)
                DEST_S11:    s11_reg <= s11_reg + mult_out_reg;
                DEST_S12:    s12_reg <= s12_reg + mult_out_reg;
                DEST_S44:    s44_reg <= s44_reg + mult_out_reg;
                DEST_ACC_LO: acc_reg <= acc_reg + {{(ACC_W - SUM_W){mult_out_reg[SUM_W-1]}},
                                                   mult_out_reg};
                DEST_ACC_HI: acc_reg <= acc_reg + {mult_out_reg, 32'b0};
                default:     acc_reg <= acc_reg;
            endcase
        end

        if ((state_reg == ST_EMIT) && out_free) begin
            m_tdata_reg <= acc_reg[ACC_W-1:FRAC_BITS];
        end
    end

    // Accumulator updates belong only to the scaling tail of an evaluation.
    `RCSC_ASSERT_NOW(a_acc_in_scale, (pend_dest_reg == DEST_ACC_LO || pend_dest_reg == DEST_ACC_HI), (state_reg == ST_SCALE || state_reg == ST_DRAIN), "accumulator update outside the scaling phase")
    // Term products must never see a partially loaded row bank.
    `RCSC_ASSERT_NOW(a_bank_loaded, (state_reg == ST_CALC), (!cap_valid_reg && !ld_issue_reg), "term pass started before the row bank was loaded")
    // A new result only appears out of the emit state.
    `RCSC_ASSERT_NOW(a_result_from_emit, $rose(m_tvalid_reg), ($past(state_reg) == ST_EMIT), "result valid raised outside the emit state")
    // A valid evaluate transaction always starts the table fetch.
    `RCSC_ASSERT_NEXT(a_eval_loads, eval_start, (state_reg == ST_LOAD), "accepted evaluate did not start the table fetch")

endmodule
